/* design/counting_sort_engine_macros.svh */
// Assertion macros for the counting sort engine.
// Included by the top level; no other dependencies.
`ifndef COUNTING_SORT_ENGINE_MACROS_SVH
`define COUNTING_SORT_ENGINE_MACROS_SVH
`ifndef ASSERT_OFF
// Checked under reset disable
`define CSE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every edge, reset included
`define CSE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSE_ASSERT(label, clk, rst, prop, msg)
`define CSE_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* design/cse_pkg.sv */
// Shared constants for the counting sort engine.
// No dependencies; used by the channel interfaces and the top level.
package cse_pkg;
   // Default sizing
   localparam int VALUE_BITS_DEF = 8;
   localparam int MAX_ITEMS_DEF  = 1024;
   // Fixed beat field widths
   localparam int VALUE_W  = 8;
   localparam int REMAIN_W = 11;
endpackage

/* design/cse_req_if.sv */
// Request channel: one beat is a push or a pop.
// Depends on cse_pkg for field widths.
interface cse_req_if;
   logic                               valid;
   logic                               ready;
   logic                               action;
   logic signed [cse_pkg::VALUE_W-1:0] value;

   modport source (output valid, action, value, input ready);
   modport sink   (input valid, action, value, output ready);
endinterface

/* design/cse_rsp_if.sv */
// Response channel: one beat per request.
// Depends on cse_pkg for field widths.
interface cse_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [cse_pkg::VALUE_W-1:0]  sorted_value;
   logic                                valid_res;
   logic                                last;
   logic                                accepted;
   logic        [cse_pkg::REMAIN_W-1:0] remaining;

   modport source (output valid, sorted_value, valid_res, last, accepted, remaining,
                   input ready);
   modport sink   (input valid, sorted_value, valid_res, last, accepted, remaining,
                   output ready);
endinterface

/* design/cse_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

/* design/counting_sort_engine.sv */
// Counting sort engine. An accepted push goes through PUSH_UPD and CNT_UPD to DONE;
// a pop goes through SCAN_CHK, which skips empty buckets from the scan cursor, then
// POP_UPD and CNT_UPD to DONE; a push to a full store or a pop on an empty store goes
// straight to DONE, which loads the response beat. One item in flight: ready again
// once the beat is loaded; a beat left waiting on rsp.ready holds the next item.
// Synchronous reset clears all 2^VALUE_BITS buckets; requests are held off till done.
`include "counting_sort_engine_macros.svh"
module counting_sort_engine #(
   parameter int VALUE_BITS = cse_pkg::VALUE_BITS_DEF,
   parameter int MAX_ITEMS  = cse_pkg::MAX_ITEMS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   cse_req_if.sink   req,
   cse_rsp_if.source rsp
);
   localparam int VW        = cse_pkg::VALUE_W;
   localparam int RW        = cse_pkg::REMAIN_W;
   localparam int NUM_CODES = 1 << VALUE_BITS;
   localparam int CODE_W    = VALUE_BITS;
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
   localparam int ALU_W     = (CNT_W > CODE_W) ? CNT_W : CODE_W;
   localparam int EXT_W     = VALUE_BITS + VW;

   localparam logic [CODE_W-1:0] TOP_CODE = CODE_W'(NUM_CODES - 1);
   localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_ITEMS);
   localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'((1 << (VALUE_BITS - 1)) - 1);
   localparam logic signed [EXT_W-1:0] SAT_LO = ~SAT_HI;

   typedef enum logic [2:0] {
      CLEAR, IDLE, PUSH_UPD, SCAN_CHK, POP_UPD, CNT_UPD, DONE
   } state_type;

   state_type         state_ff;
   logic [CODE_W-1:0] addr_ff;
   logic [CODE_W-1:0] cursor_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              pop_ff;
   logic              hit_ff;
   logic              rsp_valid_ff;
   logic signed [VW-1:0] sorted_ff;
   logic              valid_res_ff;
   logic              last_ff;
   logic              accepted_ff;
   logic [RW-1:0]     remaining_ff;

   logic signed [EXT_W-1:0]      v_ext;
   logic signed [EXT_W-1:0]      v_sat;
   logic [CODE_W-1:0]            code_in;
   logic signed [VALUE_BITS-1:0] val_out;
   logic [ALU_W-1:0]             alu_opnd;
   logic                         alu_dec;
   logic [ALU_W-1:0]             alu_sum;
   logic                         ram_wr_en;
   logic [CNT_W-1:0]             ram_wr_data;
   logic                         ram_rd_en;
   logic [CODE_W-1:0]            ram_rd_addr;
   logic [CNT_W-1:0]             ram_rd_data;
   logic                         bucket_zero;
   logic                         at_top;

   // Input value to offset-binary code, saturated to the code range
   always_comb begin
      v_ext = EXT_W'(req.value);
      if (v_ext < SAT_LO) begin
         v_sat = SAT_LO;
      end else if (v_ext > SAT_HI) begin
         v_sat = SAT_HI;
      end else begin
         v_sat = v_ext;
      end
      code_in = {~v_sat[VALUE_BITS-1], v_sat[VALUE_BITS-2:0]};
   end

   // Code back to a signed value
   assign val_out = signed'({~addr_ff[CODE_W-1], addr_ff[CODE_W-2:0]});

   // Shared increment/decrement unit
   always_comb begin
      alu_opnd = ALU_W'(addr_ff);
      alu_dec  = 1'b0;
      unique case (state_ff)
         PUSH_UPD: alu_opnd = ALU_W'(ram_rd_data);
         POP_UPD: begin
            alu_opnd = ALU_W'(ram_rd_data);
            alu_dec  = 1'b1;
         end
         CNT_UPD: begin
            alu_opnd = ALU_W'(count_ff);
            alu_dec  = pop_ff;
         end
         default: alu_opnd = ALU_W'(addr_ff);
      endcase
      alu_sum = alu_opnd + (alu_dec ? {ALU_W{1'b1}} : ALU_W'(1));
   end

   assign bucket_zero = (ram_rd_data == '0);
   assign at_top      = (addr_ff == TOP_CODE);

   // Histogram port control
   always_comb begin
      ram_wr_en   = (state_ff == CLEAR) || (state_ff == PUSH_UPD) || (state_ff == POP_UPD);
      ram_wr_data = (state_ff == CLEAR) ? '0 : alu_sum[CNT_W-1:0];
      ram_rd_en   = ((state_ff == IDLE) && req.valid) ||
                    ((state_ff == SCAN_CHK) && bucket_zero && !at_top);
      if (state_ff == IDLE) begin
         ram_rd_addr = req.action ? cursor_ff : code_in;
      end else begin
         ram_rd_addr = alu_sum[CODE_W-1:0];
      end
   end

   cse_ram #(
      .WIDTH (CNT_W),
      .DEPTH (NUM_CODES)
   ) u_hist (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (addr_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req.ready        = (state_ff == IDLE);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.sorted_value = sorted_ff;
   assign rsp.valid_res    = valid_res_ff;
   assign rsp.last         = last_ff;
   assign rsp.accepted     = accepted_ff;
   assign rsp.remaining    = remaining_ff;

   // Sequencer with response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CLEAR;
         addr_ff      <= '0;
         cursor_ff    <= TOP_CODE;
         count_ff     <= '0;
         pop_ff       <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // DONE handles its own handoff of the beat register
         if (rsp_valid_ff && rsp.ready && (state_ff != DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            CLEAR: begin
               addr_ff <= alu_sum[CODE_W-1:0];
               if (at_top) begin
                  state_ff <= IDLE;
               end
            end
            IDLE: begin
               if (req.valid) begin
                  pop_ff  <= req.action;
                  hit_ff  <= 1'b0;
                  addr_ff <= ram_rd_addr;
                  if (req.action) begin
                     state_ff <= (count_ff == '0) ? DONE : SCAN_CHK;
                  end else begin
                     state_ff <= (count_ff == MAX_CNT) ? DONE : PUSH_UPD;
                  end
               end
            end
            PUSH_UPD: begin
               if (addr_ff < cursor_ff) begin
                  cursor_ff <= addr_ff;
               end
               hit_ff   <= 1'b1;
               state_ff <= CNT_UPD;
            end
            SCAN_CHK: begin
               // skip empty buckets one per cycle
               if (!bucket_zero) begin
                  state_ff <= POP_UPD;
               end else if (at_top) begin
                  state_ff <= DONE;
               end else begin
                  addr_ff <= alu_sum[CODE_W-1:0];
               end
            end
            POP_UPD: begin
               cursor_ff <= addr_ff;
               hit_ff    <= 1'b1;
               state_ff  <= CNT_UPD;
            end
            CNT_UPD: begin
               count_ff <= alu_sum[CNT_W-1:0];
               state_ff <= DONE;
            end
            DONE: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   // Response payload, loaded as the beat is presented
   always_ff @(posedge clock) begin
      if ((state_ff == DONE) && (!rsp_valid_ff || rsp.ready)) begin
         sorted_ff    <= (pop_ff && hit_ff) ? VW'(val_out) : '0;
         valid_res_ff <= pop_ff && hit_ff;
         last_ff      <= pop_ff && hit_ff && (count_ff == '0);
         accepted_ff  <= !pop_ff && hit_ff;
         remaining_ff <= RW'(count_ff);
      end
   end

   // Checks
   `CSE_ASSERT(a_count_bound, clock, reset, count_ff <= MAX_CNT, "item count above capacity")
   `CSE_ASSERT(a_pop_push_excl, clock, reset, rsp.valid && rsp.valid_res |-> !rsp.accepted, "pop beat flagged accepted")
   `CSE_ASSERT(a_busy_after_accept, clock, reset, req.valid && req.ready |=> !req.ready, "second accept without processing")
   `CSE_ASSERT_ALWAYS(a_clear_on_reset, clock, reset |=> (state_ff == CLEAR) && !rsp.valid, "reset did not start clearing pass")
endmodule

/* tb/counting_sort_engine_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for counting_sort_engine: random push/pop traffic with a
// histogram predictor. Depends on cse_pkg, cse_req_if, cse_rsp_if and the engine RTL.
module counting_sort_engine_tb;
   localparam int CLK_PERIOD = 8;
   localparam int VALUE_W    = cse_pkg::VALUE_W;
   localparam int REMAIN_W   = cse_pkg::REMAIN_W;
   localparam int NUM_CODES  = 1 << cse_pkg::VALUE_BITS_DEF;
   localparam int CODE_BIAS  = 1 << (cse_pkg::VALUE_BITS_DEF - 1);
   localparam int MAX_HELD   = cse_pkg::MAX_ITEMS_DEF;
   // Worst pop scans every bucket; used for the settle time at the end
   localparam int SETTLE_CYCLES = NUM_CODES + 64;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } sort_op_type;

   // drain: sender waits for all outstanding results before offering this beat
   typedef struct packed {
      logic                        drain;
      sort_op_type                 op;
      logic signed [VALUE_W-1:0]   value;
   } sort_beat_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]   sorted_value;
      logic                        valid_res;
      logic                        last;
      logic                        accepted;
      logic        [REMAIN_W-1:0]  remaining;
   } sort_rsp_type;

   logic clock;
   logic reset;

   cse_req_if req_ch ();
   cse_rsp_if rsp_ch ();

   counting_sort_engine u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Predicted histogram state
   int unsigned bucket [NUM_CODES];
   int unsigned held;
   int unsigned floor_code;

   sort_beat_type pending_beats [$];
   sort_rsp_type  expected_rsp [$];
   int unsigned planned_held;
   int unsigned n_issued;
   int unsigned n_returned;
   int unsigned fault_count;

   // Apply one request to the predicted histogram and return its response
   function automatic sort_rsp_type sort_step(sort_op_type op,
                                              logic signed [VALUE_W-1:0] val);
      sort_rsp_type r;
      int           v;
      int unsigned  code;
      r = '0;
      if (op == OP_PUSH) begin
         if (held < MAX_HELD) begin
            v = val;
            // saturate into the configured value range
            if (v < -CODE_BIAS) v = -CODE_BIAS;
            if (v > CODE_BIAS - 1) v = CODE_BIAS - 1;
            code = v + CODE_BIAS;
            bucket[code]++;
            held++;
            if (code < floor_code) floor_code = code;
            r.accepted = 1'b1;
         end
      end else if (held > 0) begin
         code = floor_code % NUM_CODES;
         while (code < NUM_CODES - 1 && bucket[code] == 0) code++;
         if (bucket[code] != 0) begin
            bucket[code]--;
            held--;
            floor_code = code;
            r.sorted_value = VALUE_W'(int'(code) - CODE_BIAS);
            r.valid_res    = 1'b1;
            r.last         = (held == 0);
         end
      end
      r.remaining = held[REMAIN_W-1:0];
      return r;
   endfunction

   task automatic note_fault(string what, sort_rsp_type want, sort_rsp_type got);
      fault_count++;
      if (fault_count <= 10)
         $display("[%0t] %s: exp val=%0d vr=%b last=%b acc=%b rem=%0d | %s",
                  $realtime, what, want.sorted_value, want.valid_res, want.last,
                  want.accepted, want.remaining,
                  $sformatf("got val=%0d vr=%b last=%b acc=%b rem=%0d",
                            got.sorted_value, got.valid_res, got.last, got.accepted,
                            got.remaining));
   endtask

   // Stimulus helpers; planned_held tracks occupancy so phases can steer it
   task automatic queue_beat(sort_op_type op, logic signed [VALUE_W-1:0] val, logic drain);
      sort_beat_type b;
      b.drain = drain;
      b.op    = op;
      b.value = val;
      pending_beats.push_back(b);
      if (op == OP_PUSH) begin
         if (planned_held < MAX_HELD) planned_held++;
      end else if (planned_held > 0) begin
         planned_held--;
      end
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      logic signed [VALUE_W-1:0] v;
      case ($urandom_range(0, 3))
         0:       v = VALUE_W'(int'($urandom_range(0, 6)) - 3);   // dense cluster, duplicates
         1:       v = $urandom_range(0, 1) ? 8'sd127 : -8'sd128;
         default: v = VALUE_W'($urandom());
      endcase
      return v;
   endfunction

   function automatic sort_op_type pick_op(int unsigned pop_pct);
      return ($urandom_range(0, 99) < pop_pct) ? OP_POP : OP_PUSH;
   endfunction

   // Request driver
   sort_beat_type cur_beat;
   int unsigned tx_gap;
   int unsigned tx_count;
   logic        tx_calm;

   always @(posedge clock) begin : drive_req
      logic holding;
      logic show;
      if (reset) begin
         req_ch.valid  <= 1'b0;
         req_ch.action <= OP_PUSH;
         req_ch.value  <= '0;
         tx_gap   = 0;
         tx_count = 0;
         tx_calm  = 1'b0;
      end else begin
         holding = req_ch.valid;
         if (req_ch.valid && req_ch.ready) begin
            expected_rsp.push_back(sort_step(cur_beat.op, cur_beat.value));
            n_issued++;
            holding = 1'b0;
         end
         if (!holding) begin
            show = 1'b0;
            if (tx_gap > 0) begin
               tx_gap--;
            end else if (pending_beats.size() > 0 &&
                         (!pending_beats[0].drain || n_issued == n_returned)) begin
               cur_beat = pending_beats.pop_front();
               show     = 1'b1;
               tx_count++;
               // alternate stretches of back-to-back beats with random gaps
               if (tx_count % 32 == 0) tx_calm = ($urandom_range(0, 3) == 0);
               tx_gap = tx_calm ? 0 : $urandom_range(0, 3);
            end
            req_ch.valid <= show;
            if (show) begin
               req_ch.action <= cur_beat.op;
               req_ch.value  <= cur_beat.value;
            end
         end
      end
   end

   // Response monitor and backpressure
   int unsigned rx_stall;
   int unsigned rx_count;
   logic        rx_calm;

   always @(posedge clock) begin : watch_rsp
      sort_rsp_type got;
      sort_rsp_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         n_returned   <= 0;
         rx_stall = 0;
         rx_count = 0;
         rx_calm  = 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.sorted_value = rsp_ch.sorted_value;
            got.valid_res    = rsp_ch.valid_res;
            got.last         = rsp_ch.last;
            got.accepted     = rsp_ch.accepted;
            got.remaining    = rsp_ch.remaining;
            n_returned <= n_returned + 1;
            if (expected_rsp.size() == 0) begin
               note_fault("unexpected beat", '0, got);
            end else begin
               want = expected_rsp.pop_front();
               if (got.sorted_value !== want.sorted_value || got.valid_res !== want.valid_res ||
                   got.last !== want.last || got.accepted !== want.accepted ||
                   got.remaining !== want.remaining)
                  note_fault("mismatch", want, got);
            end
            rx_count++;
            if (rx_count % 40 == 0) rx_calm = ($urandom_range(0, 3) == 0);
            rx_stall = rx_calm ? 0 : $urandom_range(0, 3);
         end
         if (rx_stall > 0) begin
            rx_stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Hard stop in case the engine hangs
   initial begin
      #(64'd30_000_000);
      $display("simulation failed");
      $finish;
   end

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      held          = 0;
      floor_code    = NUM_CODES - 1;
      planned_held  = 0;
      n_issued      = 0;
      fault_count   = 0;
      foreach (bucket[i]) bucket[i] = 0;

      // Directed: empty pop, range extremes, duplicates, alternating bit patterns
      queue_beat(OP_POP, 8'sd0, 1'b0);
      queue_beat(OP_PUSH, 8'sd127, 1'b0);
      queue_beat(OP_PUSH, -8'sd128, 1'b0);
      queue_beat(OP_PUSH, 8'sd0, 1'b0);
      queue_beat(OP_PUSH, -8'sd1, 1'b0);
      queue_beat(OP_PUSH, 8'sd127, 1'b0);
      queue_beat(OP_PUSH, 8'sh55, 1'b0);
      queue_beat(OP_PUSH, 8'shAA, 1'b0);
      repeat (7) queue_beat(OP_POP, 8'sh5A, 1'b0);
      queue_beat(OP_POP, -8'sd1, 1'b0);
      // cursor moves down on push, then below a cursor left by a pop
      queue_beat(OP_PUSH, 8'sd5, 1'b0);
      queue_beat(OP_PUSH, 8'sd3, 1'b0);
      queue_beat(OP_POP, 8'sd0, 1'b0);
      queue_beat(OP_PUSH, -8'sd100, 1'b0);
      queue_beat(OP_POP, 8'sd0, 1'b0);
      queue_beat(OP_POP, 8'sd0, 1'b0);

      // Balanced mix: occupancy stays low and the store drains often
      for (int i = 0; i < 300; i++)
         queue_beat(pick_op(50), pick_value(), i == 150);

      // Fill to capacity, then pushes against a full store
      while (planned_held < MAX_HELD)
         queue_beat(pick_op(5), pick_value(), 1'b0);
      repeat (8) queue_beat(OP_PUSH, pick_value(), 1'b0);
      queue_beat(OP_POP, pick_value(), 1'b0);
      queue_beat(OP_PUSH, pick_value(), 1'b0);
      queue_beat(OP_PUSH, pick_value(), 1'b0);

      // Pop-heavy tail after a full pause
      for (int i = 0; i < 400; i++)
         queue_beat(pick_op(70), pick_value(), i == 0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_beats.size() != 0 || req_ch.valid || n_returned != n_issued)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      fault_count += expected_rsp.size();
      if (fault_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
